/* rtl/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg - shared types and constants of the sine PWM pulse sequencer
// Item codes, phase and half-wave encodings, configuration register indexes
// and the structs passed between the core, the pulse-width table and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 7;
    localparam int WIDTH_W     = 16;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_GAP   = 2'd1,
        PH_PULSE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SG_STOP = 2'd0,
        SG_POS  = 2'd1,
        SG_NEG  = 2'd2
    } t_sign;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_PERIOD = 2'd1;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [WIDTH_W-1:0] wr_data;
        logic [IDX_W-1:0]   rd_idx;
    } t_tbl_req;

    typedef struct packed {
        logic [WIDTH_W-1:0] rd_pos;   // entry at the current position
        logic [WIDTH_W-1:0] rd_zero;  // entry 0, used on wrap
    } t_tbl_rd;

    typedef struct packed {
        logic             pulse_level;
        logic             polarity_level;
        logic             running;
        logic [POS_W-1:0] table_position;
    } t_result;

endpackage

`default_nettype wire

/* rtl/sine_pwm_pulse_sequencer.sv */
// Latency: a result appears on m_axis in the cycle after its input transfer.
// Throughput: one item per cycle; input ready follows the output register
// (ready while it is empty or being emptied in the same cycle).
// Reset (synchronous, active low): stopped, position 0, table_length 1,
// carrier_period 500. The pulse-width table is not cleared.
// ----------------------------------------------------------------------------
// sine_pwm_pulse_sequencer - single-pin sinusoidal PWM with H-bridge polarity
// Stream in of tick, table write, start and stop items; one status result out
// per item through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_pwm_pulse_sequencer
    import sps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WIDTH_W-1:0]   i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,  // entry_index, entry_value, 2'b0
    input  wire logic [1:0]           s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata   // pulse_level, polarity_level,
                                                     // running, table_position, 6'b0
);

    t_tbl_req req;
    t_tbl_rd  rd;
    t_result  res;
    t_result  r_out;
    logic     r_out_valid, n_out_valid;
    logic     accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sps_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_action      (t_action'(s_axis_tuser)),
        .i_entry_index (s_axis_tdata[IDX_W-1:0]),
        .i_entry_value (s_axis_tdata[IDX_W+WIDTH_W-1:IDX_W]),
        .i_rd          (rd),
        .o_req         (req),
        .o_res         (res)
    );

    sps_table u_table (
        .i_clk (i_clk),
        .i_req (req),
        .o_rd  (rd)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.table_position, r_out.running,
                            r_out.polarity_level, r_out.pulse_level};

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("transfer in without a result out");

endmodule

`default_nettype wire

/* rtl/sps_table.sv */
// ----------------------------------------------------------------------------
// sps_table - pulse-width table
// Single write port, two registered read ports: one tracks the current
// position, one holds entry 0 for the wrap. Same-cycle writes are forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_table
    import sps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_tbl_req i_req,
    output t_tbl_rd       o_rd
);

    logic [WIDTH_W-1:0] r_mem [TABLE_DEPTH];
    logic [WIDTH_W-1:0] r_rd_pos;
    logic [WIDTH_W-1:0] r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
    end

    // read every cycle so the data always matches the position register
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && (i_req.wr_idx == i_req.rd_idx)) begin
            r_rd_pos <= i_req.wr_data;
        end else begin
            r_rd_pos <= r_mem[i_req.rd_idx];
        end
        if (i_req.wr_en && (i_req.wr_idx == '0)) begin
            r_rd_zero <= i_req.wr_data;
        end else begin
            r_rd_zero <= r_mem[0];
        end
    end

    assign o_rd.rd_pos  = r_rd_pos;
    assign o_rd.rd_zero = r_rd_zero;

endmodule

`default_nettype wire

/* rtl/sps_core.sv */
// ----------------------------------------------------------------------------
// sps_core - sequencer state and configuration registers
// Applies one item per cycle: tick, table write, start or stop. Gap and
// pulse timing share one saturating tick counter.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_core
    import sps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WIDTH_W-1:0]   i_cfg_data,
    input  wire logic                 i_accept,
    input  wire t_action              i_action,
    input  wire logic [IDX_W-1:0]     i_entry_index,
    input  wire logic [WIDTH_W-1:0]   i_entry_value,
    input  wire t_tbl_rd              i_rd,
    output t_tbl_req                  o_req,
    output t_result                   o_res
);

    localparam logic [POS_W-1:0] DEPTH_L = POS_W'(TABLE_DEPTH);

    t_phase             r_phase, n_phase;
    t_sign              r_sign, n_sign;
    logic [WIDTH_W-1:0] r_cnt, n_cnt;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_pin, n_pin;
    logic [POS_W-1:0]   r_table_length;
    logic [WIDTH_W-1:0] r_carrier_period;

    logic [POS_W-1:0]   eff_len;
    logic [WIDTH_W-1:0] gap_lim;
    logic [WIDTH_W-1:0] pulse_lim;
    logic [WIDTH_W-1:0] cnt_inc;
    logic               wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length   <= POS_W'(1);
            r_carrier_period <= WIDTH_W'(500);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TABLE_LENGTH:   r_table_length   <= i_cfg_data[POS_W-1:0];
                CFG_CARRIER_PERIOD: r_carrier_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sign  <= SG_STOP;
            r_cnt   <= '0;
            r_width <= '0;
            r_pos   <= '0;
            r_pin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sign  <= n_sign;
            r_cnt   <= n_cnt;
            r_width <= n_width;
            r_pos   <= n_pos;
            r_pin   <= n_pin;
        end
    end

    always_comb begin
        if (r_table_length == '0) begin
            eff_len = POS_W'(1);
        end else if (r_table_length > DEPTH_L) begin
            eff_len = DEPTH_L;
        end else begin
            eff_len = r_table_length;
        end
        gap_lim   = (r_carrier_period == '0) ? WIDTH_W'(1) : r_carrier_period;
        pulse_lim = (r_width == '0) ? WIDTH_W'(1) : r_width;
        cnt_inc   = (r_cnt == '1) ? r_cnt : r_cnt + WIDTH_W'(1);
        wrap      = (r_pos >= eff_len);
    end

    always_comb begin
        n_phase       = r_phase;
        n_sign        = r_sign;
        n_cnt         = r_cnt;
        n_width       = r_width;
        n_pos         = r_pos;
        n_pin         = r_pin;
        o_req.wr_en   = 1'b0;
        o_req.wr_idx  = i_entry_index;
        o_req.wr_data = i_entry_value;
        if (i_accept) begin
            case (i_action)
                ACT_TICK: begin
                    case (r_phase)
                        PH_GAP: begin
                            if (cnt_inc >= gap_lim) begin
                                // take the next entry, wrapping into the other half
                                if (wrap) begin
                                    n_pos   = POS_W'(1);
                                    n_sign  = (r_sign == SG_POS) ? SG_NEG : SG_POS;
                                    n_width = i_rd.rd_zero;
                                end else begin
                                    n_pos   = r_pos + POS_W'(1);
                                    n_width = i_rd.rd_pos;
                                end
                                n_pin   = 1'b1;
                                n_cnt   = '0;
                                n_phase = PH_PULSE;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                        PH_PULSE: begin
                            if (cnt_inc >= pulse_lim) begin
                                n_pin   = 1'b0;
                                n_cnt   = '0;
                                n_phase = PH_GAP;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_WRITE: begin
                    o_req.wr_en = 1'b1;
                end
                ACT_START: begin
                    // preload so the first gap ends on the next tick
                    n_pos   = '0;
                    n_sign  = SG_POS;
                    n_pin   = 1'b0;
                    n_width = '0;
                    n_phase = PH_GAP;
                    n_cnt   = (r_carrier_period == '0) ? '0
                                                       : r_carrier_period - WIDTH_W'(1);
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_pin   = 1'b0;
                    n_sign  = SG_STOP;
                    n_cnt   = '0;
                end
            endcase
        end
        o_req.rd_idx = n_pos[IDX_W-1:0];
    end

    assign o_res.pulse_level    = n_pin;
    assign o_res.polarity_level = (n_sign == SG_POS);
    assign o_res.running        = (n_phase != PH_IDLE);
    assign o_res.table_position = n_pos;

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (!r_pin && (r_sign == SG_STOP)))
        else $error("idle with pulse or polarity active");

    a_pin_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pin == (r_phase == PH_PULSE)))
        else $error("pulse pin disagrees with phase");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= DEPTH_L))
        else $error("position beyond table depth");

    a_pulse_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pin) |-> ((r_pos != '0) && (r_cnt == '0)))
        else $error("pulse began without advancing position");

endmodule

`default_nettype wire

/* bench/sine_pwm_pulse_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// sine_pwm_pulse_sequencer_tb - self-checking bench for the sine PWM sequencer
// Loads the pulse-width table, runs directed start, stop and wrap sequences and
// register edge values, then random start/tick runs under several register
// settings (most with random stalls on both streams) and a backpressure run.
// Every status transfer is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module sine_pwm_pulse_sequencer_tb;
    import sps_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WIDTH_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // entry_index, entry_value, 2'b0
    logic [1:0]           s_axis_tuser = '0;   // action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // pulse_level, polarity_level,
                                               // running, table_position, 6'b0

    sine_pwm_pulse_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // sequencer model state
    logic [WIDTH_W-1:0] width_table [TABLE_DEPTH];
    t_phase             seq_phase  = PH_IDLE;
    t_sign              seq_sign   = SG_STOP;
    logic [WIDTH_W-1:0] seq_count  = '0;
    logic [WIDTH_W-1:0] seq_width  = '0;
    logic [POS_W-1:0]   seq_pos    = '0;
    logic               seq_pin    = 1'b0;
    logic [POS_W-1:0]   cfg_len    = 7'd1;
    logic [WIDTH_W-1:0] cfg_period = 16'd500;

    t_result expected_status [$];
    int      mismatch_count = 0;
    bit      src_idle_on    = 1'b1;
    bit      sink_idle_on   = 1'b1;
    int      hold_req_count = 0;
    int      hold_served    = 0;
    int      hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_result predict_status(t_action act, logic [IDX_W-1:0] idx,
                                               logic [WIDTH_W-1:0] val);
        logic [16:0]        nxt;
        logic [16:0]        lim;
        logic [POS_W-1:0]   len;
        t_result            r;
        len = (cfg_len == 0) ? 7'd1 : (cfg_len > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : cfg_len;
        case (act)
            ACT_TICK: begin
                nxt = {1'b0, seq_count} + 17'd1;
                if (nxt > 17'hFFFF) nxt = 17'hFFFF;
                if (seq_phase == PH_GAP) begin
                    lim = (cfg_period == 0) ? 17'd1 : {1'b0, cfg_period};
                    if (nxt >= lim) begin
                        // wrap the half period and flip polarity before taking the entry
                        if (seq_pos >= len) begin
                            seq_pos  = '0;
                            seq_sign = (seq_sign == SG_POS) ? SG_NEG : SG_POS;
                        end
                        seq_width = width_table[seq_pos[IDX_W-1:0]];
                        seq_pos   = seq_pos + 7'd1;
                        seq_pin   = 1'b1;
                        seq_count = '0;
                        seq_phase = PH_PULSE;
                    end else begin
                        seq_count = nxt[15:0];
                    end
                end else if (seq_phase == PH_PULSE) begin
                    lim = (seq_width == 0) ? 17'd1 : {1'b0, seq_width};
                    if (nxt >= lim) begin
                        seq_pin   = 1'b0;
                        seq_count = '0;
                        seq_phase = PH_GAP;
                    end else begin
                        seq_count = nxt[15:0];
                    end
                end
            end
            ACT_WRITE: width_table[idx] = val;
            ACT_START: begin
                seq_pos   = '0;
                seq_sign  = SG_POS;
                seq_pin   = 1'b0;
                seq_width = '0;
                seq_phase = PH_GAP;
                seq_count = (cfg_period == 0) ? '0 : cfg_period - 16'd1;
            end
            default: begin
                seq_phase = PH_IDLE;
                seq_pin   = 1'b0;
                seq_sign  = SG_STOP;
                seq_count = '0;
            end
        endcase
        r.pulse_level    = seq_pin;
        r.polarity_level = (seq_sign == SG_POS);
        r.running        = (seq_phase != PH_IDLE);
        r.table_position = seq_pos;
        return r;
    endfunction

    // Mostly short widths so pulses end; now and then any 16-bit value.
    function automatic logic [WIDTH_W-1:0] random_width();
        if ($urandom_range(99) < 15) return WIDTH_W'($urandom);
        return WIDTH_W'($urandom_range(6));
    endfunction

    // Call right after a rising edge; returns in the step of the transfer or
    // after a random gap with valid dropped.
    task automatic send_item(input t_action act, input logic [IDX_W-1:0] idx,
                             input logic [WIDTH_W-1:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_status.push_back(predict_status(act, idx, val));
        if (src_idle_on) begin
            gap = 0;
            while ($urandom_range(99) < 38) gap++;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drain();
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    // Drop valid, let all status transfers arrive and the output register settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TABLE_LENGTH) cfg_len = data[POS_W-1:0];
        else if (idx == CFG_CARRIER_PERIOD) cfg_period = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random_items(input int count);
        int sent;
        int ticks;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 85) begin
                // well-formed run: start, a train of ticks with a few table writes
                send_item(ACT_START, IDX_W'($urandom), WIDTH_W'($urandom));
                sent++;
                ticks = $urandom_range(10, 150);
                repeat (ticks) begin
                    if ($urandom_range(99) < 8)
                        send_item(ACT_WRITE, IDX_W'($urandom), random_width());
                    else
                        send_item(ACT_TICK, IDX_W'($urandom), WIDTH_W'($urandom));
                    sent++;
                end
                if ($urandom_range(1)) begin
                    send_item(ACT_STOP, IDX_W'($urandom), WIDTH_W'($urandom));
                    sent++;
                end
            end else begin
                send_item(t_action'($urandom_range(3)), IDX_W'($urandom), random_width());
                sent++;
            end
        end
    endtask

    task automatic test_table_load();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(ACT_WRITE, IDX_W'(i), random_width());
    endtask

    task automatic test_start_stop_wrap();
        wait_idle();
        write_reg(CFG_TABLE_LENGTH, 16'd2);
        write_reg(CFG_CARRIER_PERIOD, 16'd2);
        send_item(ACT_WRITE, 6'd0, 16'd0);      // zero-width pulse
        send_item(ACT_WRITE, 6'd1, 16'd2);
        send_item(ACT_TICK, 6'd0, 16'd0);       // tick while stopped
        send_item(ACT_STOP, 6'd0, 16'd0);       // stop while stopped
        send_item(ACT_START, 6'd0, 16'd0);
        repeat (8) send_item(ACT_TICK, 6'd0, 16'd0);   // through wrap and polarity flip
        send_item(ACT_WRITE, 6'd1, 16'd1);      // table write while running
        repeat (3) send_item(ACT_TICK, 6'd0, 16'd0);
        send_item(ACT_START, 6'd0, 16'd0);      // restart while running
        send_item(ACT_TICK, 6'd0, 16'd0);
        send_item(ACT_STOP, 6'd0, 16'd0);
    endtask

    task automatic test_register_edges();
        // lower the carrier period in the middle of a gap
        wait_idle();
        write_reg(CFG_CARRIER_PERIOD, 16'd6);
        send_item(ACT_START, 6'd0, 16'd0);
        repeat (4) send_item(ACT_TICK, 6'd0, 16'd0);
        wait_idle();
        write_reg(CFG_CARRIER_PERIOD, 16'd2);
        send_item(ACT_TICK, 6'd0, 16'd0);
        send_item(ACT_STOP, 6'd0, 16'd0);
        // widest values, length masked to zero, writes to unused indexes
        send_item(ACT_WRITE, 6'd0, 16'hFFFF);
        send_item(ACT_WRITE, 6'd63, 16'hFFFF);
        wait_idle();
        write_reg(CFG_TABLE_LENGTH, 16'hFF80);
        write_reg(CFG_CARRIER_PERIOD, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        send_item(ACT_START, 6'd0, 16'd0);
        repeat (4) send_item(ACT_TICK, 6'd0, 16'd0);
        send_item(ACT_STOP, 6'd0, 16'd0);
        send_item(ACT_WRITE, 6'd0, 16'd3);
    endtask

    task automatic test_random_phase(input logic [WIDTH_W-1:0] len_data,
                                     input logic [WIDTH_W-1:0] period, input int count,
                                     input bit src_idle, input bit sink_idle);
        wait_idle();
        write_reg(CFG_TABLE_LENGTH, len_data);
        write_reg(CFG_CARRIER_PERIOD, period);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        run_random_items(count);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(CFG_TABLE_LENGTH, 16'd4);
        write_reg(CFG_CARRIER_PERIOD, 16'd1);
        src_idle_on = 1'b0;
        hold_req_count++;
        run_random_items(80);
        // pause the input until every status transfer is back
        wait_idle();
        repeat (5) @(posedge i_clk);
        src_idle_on = 1'b1;
        run_random_items(20);
    endtask

    // receiver side: random stalls, plus a long hold when asked
    always @(posedge i_clk) begin
        if (hold_served != hold_req_count) begin
            hold_served = hold_req_count;
            hold_left   = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(sink_idle_on && ($urandom_range(99) < 38));
        end
    end

    always @(posedge i_clk) begin : status_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pulse_level    = m_axis_tdata[0];
            got.polarity_level = m_axis_tdata[1];
            got.running        = m_axis_tdata[2];
            got.table_position = m_axis_tdata[9:3];
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected status transfer, actual %h", $realtime, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_status.pop_front();
                if (got.pulse_level !== want.pulse_level) begin
                    $display("%0t: pulse_level expected %0b actual %0b",
                             $realtime, want.pulse_level, got.pulse_level);
                    mismatch_count++;
                end
                if (got.polarity_level !== want.polarity_level) begin
                    $display("%0t: polarity_level expected %0b actual %0b",
                             $realtime, want.polarity_level, got.polarity_level);
                    mismatch_count++;
                end
                if (got.running !== want.running) begin
                    $display("%0t: running expected %0b actual %0b",
                             $realtime, want.running, got.running);
                    mismatch_count++;
                end
                if (got.table_position !== want.table_position) begin
                    $display("%0t: table_position expected %0d actual %0d",
                             $realtime, want.table_position, got.table_position);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_start_stop_wrap();
        test_register_edges();
        test_random_phase(16'd1, 16'd1, 170, 1'b1, 1'b1);
        test_random_phase(16'd3, 16'd2, 170, 1'b1, 1'b1);
        test_random_phase(16'hFF85, 16'd0, 170, 1'b0, 1'b0);   // length masked to 5, no stalls
        test_random_phase(16'd64, 16'd1, 170, 1'b1, 1'b1);
        test_random_phase(16'd127, 16'd3, 120, 1'b1, 1'b1);    // saturates to full depth
        test_random_phase(16'd0, 16'd5, 120, 1'b1, 1'b1);
        test_backpressure();

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
